FILE: rtl/lcd_slt_pkg.sv
// ---------------------------------------------------------------------------
// LCD scanline timing package
// Shared widths, timing constants and codes for the scanline timing block.
// ---------------------------------------------------------------------------
package lcd_slt_pkg;

    localparam int ELAPSED_W = 6;
    localparam int ACCUM_W   = 10;
    localparam int LINE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Line timing, in clock cycles from the start of a line.
    localparam logic [ACCUM_W-1:0] LINE_CYCLES  = ACCUM_W'(456);
    localparam logic [ACCUM_W-1:0] OAM_END      = ACCUM_W'(80);
    localparam logic [ACCUM_W-1:0] TRANSFER_END = ACCUM_W'(252);
    localparam logic [ACCUM_W-1:0] HBLANK_END   = ACCUM_W'(456);

    // Line numbering.
    localparam logic [LINE_W-1:0] VBLANK_LINE = LINE_W'(144);
    localparam logic [LINE_W-1:0] LAST_LINE   = LINE_W'(153);

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_COMPARE   = 2'd0,
        CFG_HBLANK_IRQ_EN  = 2'd1,
        CFG_OAM_IRQ_EN     = 2'd2,
        CFG_COMPARE_IRQ_EN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LINE_W-1:0] draw_line;
        logic              draw_strobe;
        logic              lcd_request;
        logic              vblank_request;
        logic              coincidence;
        logic [LINE_W-1:0] current_line;
        t_mode             display_mode;
    } t_result;

endpackage

FILE: rtl/lcd_scanline_timing.sv
// ---------------------------------------------------------------------------
// LCD scanline timing
// Steps the display mode and line counter of an LCD controller from ticks.
// ---------------------------------------------------------------------------
// Usage:
// Each beat on the slave stream is one tick carrying the number of clock
// cycles elapsed since the previous tick. For every tick the block emits
// exactly one beat on the master stream with the display mode, the line
// counter, the coincidence flag, the vblank and LCD interrupt requests and
// a draw strobe with the line that just finished.
// The result is registered: a tick accepted at one edge has its result
// beat valid right after that edge. Throughput is one tick per cycle while
// the receiver does not stall, set by the single register stage that holds
// the result; line state and result are written in the cycle taking the tick.
// When the receiver stalls, the result is held and the slave side stays
// ready only if the held result is taken in the same cycle.
// Configuration writes on the cfg channel are always accepted (ready is
// tied high) and are meant to happen while no tick is in flight.
// Reset clears the configuration, line state and valid flag (not the result
// payload), puts the line counter at zero and the mode at OAM search.
// ---------------------------------------------------------------------------
module lcd_scanline_timing (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Tick stream. tdata: [5:0] elapsed_cycles, [7:6] zero.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [lcd_slt_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Result stream. tdata: [1:0] display_mode, [9:2] current_line,
    // [10] coincidence, [11] vblank_request, [12] lcd_request,
    // [13] draw_strobe, [21:14] draw_line, [23:22] zero.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [lcd_slt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lcd_slt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lcd_slt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lcd_slt_pkg::*;

    // Configuration registers.
    logic [LINE_W-1:0]  r_line_compare;
    logic               r_hblank_irq_en;
    logic               r_oam_irq_en;
    logic               r_compare_irq_en;

    // Line timing state.
    logic [ACCUM_W-1:0] r_accum, n_accum;
    logic [LINE_W-1:0]  r_line, n_line;
    t_mode              r_mode, n_mode;
    logic               r_coin, n_coin;

    // Result register.
    logic               r_out_valid;
    t_result            r_result, n_result;

    logic               s_accept;
    logic [ACCUM_W:0]   sum;
    logic [ACCUM_W-1:0] accum_sat;
    logic               vblank_req;
    logic               lcd_req;
    logic               strobe;
    logic [LINE_W-1:0]  dline;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - $bits(t_result))'(0), r_result};

    // Next line state and result for the tick on the input bus.
    always_comb begin
        sum = {1'b0, r_accum} + (ACCUM_W+1)'(i_s_axis_tdata[ELAPSED_W-1:0]);
        // The cycle count saturates rather than wrapping.
        accum_sat = sum[ACCUM_W] ? '1 : sum[ACCUM_W-1:0];

        n_accum    = accum_sat;
        n_line     = r_line;
        n_mode     = r_mode;
        n_coin     = r_coin;
        vblank_req = 1'b0;
        lcd_req    = 1'b0;
        strobe     = 1'b0;
        dline      = '0;

        // At most one mode step per tick, judged on the old mode and line.
        case (r_mode)
            MODE_OAM: begin
                if (accum_sat >= OAM_END) begin
                    n_mode = MODE_XFER;
                end
            end
            MODE_XFER: begin
                if (accum_sat >= TRANSFER_END) begin
                    n_mode  = MODE_HBLANK;
                    lcd_req = r_hblank_irq_en;
                end
            end
            MODE_HBLANK: begin
                if (r_line == VBLANK_LINE) begin
                    vblank_req = 1'b1;
                    n_mode     = MODE_VBLANK;
                end else if (accum_sat >= HBLANK_END) begin
                    n_mode  = MODE_OAM;
                    lcd_req = r_oam_irq_en;
                end
            end
            default: begin
            end
        endcase

        // Line end: compare, strobe a draw for visible lines, advance or wrap.
        if (accum_sat >= LINE_CYCLES) begin
            n_accum = '0;
            if (r_line == r_line_compare) begin
                n_coin = 1'b1;
                if (r_compare_irq_en) begin
                    lcd_req = 1'b1;
                end
            end else begin
                n_coin = 1'b0;
            end
            if (r_line < VBLANK_LINE) begin
                strobe = 1'b1;
                dline  = r_line;
                n_line = r_line + LINE_W'(1);
            end else if (r_line > LAST_LINE) begin
                if (r_oam_irq_en) begin
                    lcd_req = 1'b1;
                end
                n_mode = MODE_OAM;
                n_line = '0;
            end else begin
                n_line = r_line + LINE_W'(1);
            end
        end

        n_result.display_mode   = n_mode;
        n_result.current_line   = n_line;
        n_result.coincidence    = n_coin;
        n_result.vblank_request = vblank_req;
        n_result.lcd_request    = lcd_req;
        n_result.draw_strobe    = strobe;
        n_result.draw_line      = dline;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_compare   <= '0;
            r_hblank_irq_en  <= 1'b0;
            r_oam_irq_en     <= 1'b0;
            r_compare_irq_en <= 1'b0;
            r_accum          <= '0;
            r_line           <= '0;
            r_mode           <= MODE_OAM;
            r_coin           <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_LINE_COMPARE:   r_line_compare   <= i_cfg_data[LINE_W-1:0];
                    CFG_HBLANK_IRQ_EN:  r_hblank_irq_en  <= i_cfg_data[0];
                    CFG_OAM_IRQ_EN:     r_oam_irq_en     <= i_cfg_data[0];
                    CFG_COMPARE_IRQ_EN: r_compare_irq_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (s_accept) begin
                r_accum     <= n_accum;
                r_line      <= n_line;
                r_mode      <= n_mode;
                r_coin      <= n_coin;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_result <= n_result;
        end
    end

endmodule

FILE: tb/lcd_scanline_timing_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LCD scanline timing testbench
// Sends elapsed-cycle ticks into the scanline timing block and checks every
// result beat against a cycle-accurate model of the mode and line sequencer,
// across several register settings and with random stalls on both streams.
// ---------------------------------------------------------------------------
module lcd_scanline_timing_test;

    import lcd_slt_pkg::*;

    // Random phases keep going until enough ticks have gone in; each phase
    // runs under its own register setting.
    localparam int RANDOM_TICKS = 650;
    localparam int PHASE_TICKS  = 130;
    localparam int CLOSING_TICKS = 150;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  tick_valid = 1'b0;
    logic                  tick_ready;
    logic [IN_TDATA_W-1:0] tick_data = '0;

    logic                   status_valid;
    logic                   status_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] status_data;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    t_cfg_idx              cfg_index = CFG_LINE_COMPARE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Ticks waiting to be sent, and the status beats predicted for ticks that
    // the block has taken but whose result has not come back yet.
    logic [ELAPSED_W-1:0] pending_ticks[$];
    t_result              predicted_status[$];

    // Model copy of the block's registers.
    logic [LINE_W-1:0]  cmp_line = '0;
    logic               hb_irq_en = 1'b0;
    logic               oam_irq_en = 1'b0;
    logic               cmp_irq_en = 1'b0;
    logic [ACCUM_W-1:0] accum_q = '0;
    logic [LINE_W-1:0]  line_q = '0;
    t_mode              mode_q = MODE_OAM;
    logic               coin_q = 1'b0;

    int    error_count = 0;
    bit    idle_on = 1'b1;
    int    send_gap = 0;
    int    hold_left = 0;
    t_result want;
    t_result got;

    always #5 i_clk = ~i_clk;

    lcd_scanline_timing u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (tick_valid),
        .o_s_axis_tready (tick_ready),
        .i_s_axis_tdata  (tick_data),
        .o_m_axis_tvalid (status_valid),
        .i_m_axis_tready (status_ready),
        .o_m_axis_tdata  (status_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Advances the model by one tick and returns the status beat it causes.
    // The mode step looks at the old mode, the old line and the new cycle
    // count; the line-end handling that follows also uses the old line.
    function automatic t_result advance_timing(logic [ELAPSED_W-1:0] elapsed);
        t_result            r;
        logic [ACCUM_W:0]   sum;
        logic [LINE_W-1:0]  old_line;
        r = '0;
        old_line = line_q;
        sum = {1'b0, accum_q} + (ACCUM_W+1)'(elapsed);
        accum_q = sum[ACCUM_W] ? '1 : sum[ACCUM_W-1:0];

        // Only one mode transition per tick.
        case (mode_q)
            MODE_OAM: begin
                if (accum_q >= OAM_END) mode_q = MODE_XFER;
            end
            MODE_XFER: begin
                if (accum_q >= TRANSFER_END) begin
                    mode_q = MODE_HBLANK;
                    if (hb_irq_en) r.lcd_request = 1'b1;
                end
            end
            MODE_HBLANK: begin
                // Hblank on the first blank line drops into vblank right away,
                // whatever the cycle count is.
                if (old_line == VBLANK_LINE) begin
                    r.vblank_request = 1'b1;
                    mode_q = MODE_VBLANK;
                end else if (accum_q >= HBLANK_END) begin
                    mode_q = MODE_OAM;
                    if (oam_irq_en) r.lcd_request = 1'b1;
                end
            end
            default: ;
        endcase

        if (accum_q >= LINE_CYCLES) begin
            accum_q = '0;
            coin_q = (old_line == cmp_line);
            if (coin_q && cmp_irq_en) r.lcd_request = 1'b1;
            if (old_line < VBLANK_LINE) begin
                r.draw_strobe = 1'b1;
                r.draw_line = old_line;
                line_q = old_line + LINE_W'(1);
            end else if (old_line > LAST_LINE) begin
                // Past the last line: back to line zero in OAM search.
                if (oam_irq_en) r.lcd_request = 1'b1;
                mode_q = MODE_OAM;
                line_q = '0;
            end else begin
                line_q = old_line + LINE_W'(1);
            end
        end

        r.display_mode = mode_q;
        r.current_line = line_q;
        r.coincidence = coin_q;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // Register writes update the model at the edge that takes them. Only the
    // low bit of an enable write counts; the rest of the byte is dropped.
    always @(posedge i_clk) begin
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LINE_COMPARE:   cmp_line <= cfg_data;
                CFG_HBLANK_IRQ_EN:  hb_irq_en <= cfg_data[0];
                CFG_OAM_IRQ_EN:     oam_irq_en <= cfg_data[0];
                CFG_COMPARE_IRQ_EN: cmp_irq_en <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Tick driver. A beat is held until taken; the prediction is made at the
    // edge where the block accepts it. Between beats the driver may go quiet
    // for a random burst of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_valid <= 1'b0;
        end else if (tick_valid && !tick_ready) begin
            // Beat still waiting for the block.
        end else begin
            if (tick_valid) predicted_status.push_back(advance_timing(tick_data[ELAPSED_W-1:0]));
            if (send_gap != 0) begin
                send_gap--;
                tick_valid <= 1'b0;
            end else if (pending_ticks.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
                // Idle this cycle and then for as many more as send_gap draws.
                send_gap = $urandom_range(0, 12);
                tick_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                tick_valid <= 1'b1;
                tick_data <= IN_TDATA_W'(pending_ticks.pop_front());
            end else begin
                tick_valid <= 1'b0;
            end
        end
    end

    // Status monitor: each beat taken is compared with the oldest prediction.
    // Ready drops for random bursts as well.
    always @(posedge i_clk) begin
        if (status_valid && status_ready) begin
            if (predicted_status.size() == 0) begin
                $error("status beat with no tick outstanding: tdata %h", status_data);
                error_count++;
            end else begin
                want = predicted_status.pop_front();
                got = t_result'(status_data[$bits(t_result)-1:0]);
                check_field("display_mode", 32'(want.display_mode), 32'(got.display_mode));
                check_field("current_line", 32'(want.current_line), 32'(got.current_line));
                check_field("coincidence", 32'(want.coincidence), 32'(got.coincidence));
                check_field("vblank_request", 32'(want.vblank_request),
                            32'(got.vblank_request));
                check_field("lcd_request", 32'(want.lcd_request), 32'(got.lcd_request));
                check_field("draw_strobe", 32'(want.draw_strobe), 32'(got.draw_strobe));
                check_field("draw_line", 32'(want.draw_line), 32'(got.draw_line));
                check_field("tdata padding", 0,
                            32'(status_data[OUT_TDATA_W-1:$bits(t_result)]));
            end
        end

        if (!i_rst_n) begin
            status_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            status_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 12);
            status_ready <= 1'b0;
        end else begin
            status_ready <= 1'b1;
        end
    end

    // Writes all four registers in one burst; valid stays up between them.
    task automatic load_settings(logic [CFG_DATA_W-1:0] cmp_val,
                                 logic [CFG_DATA_W-1:0] hb_val,
                                 logic [CFG_DATA_W-1:0] oam_val,
                                 logic [CFG_DATA_W-1:0] cmp_en_val);
        t_cfg_idx              reg_order[4];
        logic [CFG_DATA_W-1:0] reg_value[4];
        reg_order = '{CFG_LINE_COMPARE, CFG_HBLANK_IRQ_EN, CFG_OAM_IRQ_EN,
                      CFG_COMPARE_IRQ_EN};
        reg_value = '{cmp_val, hb_val, oam_val, cmp_en_val};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_order[k];
            cfg_data <= reg_value[k];
            do @(posedge i_clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Queues random ticks, a few at a time. Most are long steps so that the
    // frame moves along; some are short, down to zero, to hit the thresholds
    // exactly and to exercise ticks that change nothing.
    task automatic feed_ticks(int count);
        int pick;
        repeat (count) begin
            while (pending_ticks.size() >= 4) @(negedge i_clk);
            pick = $urandom_range(0, 9);
            if (pick < 7) pending_ticks.push_back(ELAPSED_W'($urandom_range(40, 63)));
            else if (pick < 9) pending_ticks.push_back(ELAPSED_W'($urandom_range(0, 63)));
            else pending_ticks.push_back(ELAPSED_W'($urandom_range(0, 3)));
        end
    endtask

    // Settled once the queues are empty and no beat is on either stream.
    // Checked at the falling edge, where nothing is in motion.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_ticks.size() != 0 || tick_valid || predicted_status.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        int random_ticks;
        int phase;
        logic [CFG_DATA_W-1:0] cmp_pick;
        logic [CFG_DATA_W-1:0] en_fill;
        random_ticks = 0;
        phase = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed start: all interrupts on (upper data bits set on the hblank and
        // compare enables to show they are dropped) and compare on line zero. The
        // first line walks through OAM search, transfer and hblank, landing exactly
        // on each boundary, so the end of line zero raises the coincidence interrupt.
        load_settings(8'h00, 8'hFF, 8'h01, 8'hFD);
        pending_ticks = '{6'd0, 6'd63, 6'd1, 6'd16, 6'd63, 6'd63, 6'd45, 6'd1,
                          6'd63, 6'd63, 6'd42, 6'd35, 6'd1, 6'd21, 6'd42, 6'd62,
                          6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63};
        wait_idle();

        // Random phases, each under its own register setting. The compare
        // line rotates between a line just ahead of the counter, the two
        // extremes, the blank lines and anything at all.
        while (random_ticks < RANDOM_TICKS) begin
            case (phase % 4)
                0: cmp_pick = line_q + CFG_DATA_W'($urandom_range(1, 12));
                1: cmp_pick = ((phase / 4) % 2 == 0) ? 8'hFF : 8'h00;
                2: cmp_pick = CFG_DATA_W'($urandom_range(VBLANK_LINE, LAST_LINE + 1));
                default: cmp_pick = CFG_DATA_W'($urandom_range(0, 255));
            endcase
            if (phase == 1) begin
                // All interrupts off, with the unused data bits high.
                en_fill = 8'hFE;
                load_settings(cmp_pick, en_fill, en_fill, en_fill);
            end else begin
                load_settings(cmp_pick, CFG_DATA_W'($urandom_range(0, 255)),
                              CFG_DATA_W'($urandom_range(0, 255)),
                              CFG_DATA_W'($urandom_range(0, 255)));
            end
            idle_on = ($urandom_range(0, 3) != 0);
            feed_ticks(PHASE_TICKS);
            random_ticks += PHASE_TICKS;
            wait_idle();
            phase++;
        end

        // Closing stretch at full rate with every interrupt enabled.
        idle_on = 1'b0;
        load_settings(line_q + 8'd2, 8'h01, 8'h01, 8'h01);
        feed_ticks(CLOSING_TICKS);
        wait_idle();

        // A few more cycles to catch any stray result beat.
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[lcd_scanline_timing] OK");
        end else begin
            $display("[lcd_scanline_timing] ERROR");
        end
        $finish;
    end

    // Run limit, several times the slowest legal run.
    initial begin
        #(8_000_000);
        $display("[lcd_scanline_timing] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/lcd_slt_pkg.sv
rtl/lcd_scanline_timing.sv
tb/lcd_scanline_timing_test.sv
